@@ rtl/twppc_pkg.sv @@
package twppc_pkg;

  localparam int TRACE_LEN_DEF   = 2048;
  localparam int SAMPLE_BITS_DEF = 13;

  localparam int REG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int POS_OUT_W = 11;
  localparam int COUNT_W   = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 2'd2;

  localparam logic [REG_W-1:0] WINDOW_START_RST   = 12'd800;
  localparam logic [REG_W-1:0] WINDOW_END_RST     = 12'd1500;
  localparam logic [REG_W-1:0] PEAK_THRESHOLD_RST = 12'd200;

  typedef struct packed {
    logic [REG_W-1:0] window_start;
    logic [REG_W-1:0] window_end;
    logic [REG_W-1:0] peak_threshold;
  } cfg_t;

endpackage

@@ rtl/twppc_cfg.sv @@
module twppc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [twppc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [twppc_pkg::REG_W-1:0]     cfg_wdata,
  output twppc_pkg::cfg_t                 cfg
);
  import twppc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WINDOW_START:   cfg_nxt.window_start   = cfg_wdata;
        CFG_WINDOW_END:     cfg_nxt.window_end     = cfg_wdata;
        CFG_PEAK_THRESHOLD: cfg_nxt.peak_threshold = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_start   <= WINDOW_START_RST;
      cfg_r.window_end     <= WINDOW_END_RST;
      cfg_r.peak_threshold <= PEAK_THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/twppc_in_reg.sv @@
module twppc_in_reg #(
  parameter int SAMPLE_BITS = twppc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_tlast,
  input  logic                   out_free,
  output logic                   step,
  output logic [SAMPLE_BITS-1:0] sample,
  output logic                   last
);
  import twppc_pkg::*;

  logic                   valid_r;
  logic                   valid_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   last_r;

  // a non-last item always moves on; a last one needs the result slot
  assign step      = valid_r && (!last_r || out_free);
  assign in_tready = !valid_r || step;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sample_r <= in_sample;
      last_r   <= in_tlast;
    end
  end

  assign sample = sample_r;
  assign last   = last_r;

endmodule

@@ rtl/twppc_core.sv @@
module twppc_core #(
  parameter int TRACE_LEN   = twppc_pkg::TRACE_LEN_DEF,
  parameter int SAMPLE_BITS = twppc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  twppc_pkg::cfg_t                   cfg,
  input  logic                              step,
  input  logic [SAMPLE_BITS-1:0]            sample,
  input  logic                              last,
  output logic                              res_load,
  output logic [SAMPLE_BITS-1:0]            res_peak_value,
  output logic [twppc_pkg::POS_OUT_W-1:0]   res_peak_position,
  output logic                              res_peak_found,
  output logic [twppc_pkg::COUNT_W-1:0]     res_pulse_count
);
  import twppc_pkg::*;

  localparam int PW   = $clog2(TRACE_LEN + 1);
  localparam int CMPW = (PW > REG_W) ? PW : REG_W;
  localparam int TW   = (SAMPLE_BITS + 2 > REG_W + 1) ? SAMPLE_BITS + 2 : REG_W + 1;
  localparam logic [PW-1:0] POS_END = PW'(TRACE_LEN);

  logic [PW-1:0]          pos_r,        pos_nxt;
  logic [SAMPLE_BITS-1:0] best_value_r, best_value_nxt;
  logic [POS_OUT_W-1:0]   best_pos_r,   best_pos_nxt;
  logic                   have_peak_r,  have_peak_nxt;
  logic                   pulse_open_r, pulse_open_nxt;
  logic [COUNT_W-1:0]     pulses_r,     pulses_nxt;

  logic [CMPW-1:0]        pos_x;
  logic [CMPW-1:0]        ws_x;
  logic [CMPW-1:0]        we_x;
  logic                   in_win;
  logic signed [TW-1:0]   s_x;
  logic signed [TW-1:0]   s_dbl;
  logic signed [TW-1:0]   thr_x;
  logic                   above;
  logic                   above_half;
  logic                   better;

  assign pos_x  = CMPW'(pos_r);
  assign ws_x   = CMPW'(cfg.window_start);
  assign we_x   = CMPW'(cfg.window_end);
  assign in_win = (pos_x >= ws_x) && (pos_x < we_x) && (pos_r < POS_END);

  assign s_x        = TW'($signed(sample));
  assign s_dbl      = s_x <<< 1;
  assign thr_x      = $signed(TW'(cfg.peak_threshold));
  assign above      = s_x > thr_x;
  assign above_half = s_dbl > thr_x;
  assign better     = !have_peak_r || ($signed(sample) > $signed(best_value_r));

  always_comb begin
    pos_nxt        = pos_r;
    best_value_nxt = best_value_r;
    best_pos_nxt   = best_pos_r;
    have_peak_nxt  = have_peak_r;
    pulse_open_nxt = pulse_open_r;
    pulses_nxt     = pulses_r;
    if (in_win) begin
      if (better) begin
        best_value_nxt = sample;
        best_pos_nxt   = POS_OUT_W'(pos_r);
        have_peak_nxt  = 1'b1;
      end
      if (pulse_open_r) begin
        if (!above_half) begin
          pulse_open_nxt = 1'b0;
        end
      end else if (above) begin
        if (pulses_r != COUNT_MAX) begin
          pulses_nxt = pulses_r + 1'b1;
        end
        pulse_open_nxt = 1'b1;
      end
    end
    if (pos_r < POS_END) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  assign res_load          = step && last;
  assign res_peak_value    = best_value_nxt;
  assign res_peak_position = best_pos_nxt;
  assign res_peak_found    = have_peak_nxt;
  assign res_pulse_count   = pulses_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      best_value_r <= '0;
      best_pos_r   <= '0;
      have_peak_r  <= 1'b0;
      pulse_open_r <= 1'b0;
      pulses_r     <= '0;
    end else if (step) begin
      if (last) begin
        pos_r        <= '0;
        best_value_r <= '0;
        best_pos_r   <= '0;
        have_peak_r  <= 1'b0;
        pulse_open_r <= 1'b0;
        pulses_r     <= '0;
      end else begin
        pos_r        <= pos_nxt;
        best_value_r <= best_value_nxt;
        best_pos_r   <= best_pos_nxt;
        have_peak_r  <= have_peak_nxt;
        pulse_open_r <= pulse_open_nxt;
        pulses_r     <= pulses_nxt;
      end
    end
  end

  a_open_counted: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_open_r |-> pulses_r != '0)
    else $error("open pulse with zero count");

  a_no_peak_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !have_peak_r |-> (best_value_r == '0 && best_pos_r == '0))
    else $error("peak state set without a peak");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_END)
    else $error("position beyond trace length");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> (pos_r == '0 && pulses_r == '0 && !pulse_open_r))
    else $error("trace state not cleared after last sample");

endmodule

@@ rtl/twppc_out_reg.sv @@
module twppc_out_reg #(
  parameter int SAMPLE_BITS = twppc_pkg::SAMPLE_BITS_DEF,
  parameter int TDATA_W     = ((SAMPLE_BITS + 23 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            res_load,
  input  logic [SAMPLE_BITS-1:0]          res_peak_value,
  input  logic [twppc_pkg::POS_OUT_W-1:0] res_peak_position,
  input  logic                            res_peak_found,
  input  logic [twppc_pkg::COUNT_W-1:0]   res_pulse_count,
  output logic                            out_free,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [TDATA_W-1:0]              out_tdata
);
  import twppc_pkg::*;

  localparam int FIELD_W = SAMPLE_BITS + POS_OUT_W + 1 + COUNT_W;

  logic               valid_r;
  logic               valid_nxt;
  logic [TDATA_W-1:0] data_r;

  assign out_free  = !valid_r || out_tready;
  assign valid_nxt = res_load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      data_r <= TDATA_W'({res_pulse_count, res_peak_found, res_peak_position,
                          res_peak_value});
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  a_width_fits: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free && (FIELD_W <= TDATA_W))
    else $error("result loaded while output slot busy");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_tready |=> valid_r && $stable(data_r))
    else $error("stalled result changed");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> valid_r)
    else $error("loaded result not presented");

endmodule

@@ rtl/trace_window_peak_pulse_count.sv @@
// Windowed peak finder with hysteresis pulse counter. Streams one trace sample
// per transfer (tlast on the final sample); samples whose position lies in
// [window_start, window_end) feed a running maximum with first-occurrence
// position and a pulse counter that opens above peak_threshold and closes
// once twice the sample no longer exceeds it. On the last sample one result
// transfer carries peak, position, found flag and count, and the per-trace
// state clears. Throughput is one sample per clock: each sample passes an
// input register and one stage of compare/update logic, and the result sits
// in an output register, so samples keep flowing while a result waits. Only
// a last sample can stall, and only while the previous result is still
// untaken. out_tvalid rises once the result of a last sample is registered.
// Configuration writes take effect on the next clock and should be made
// while no trace is in flight.
module trace_window_peak_pulse_count #(
  parameter int TRACE_LEN   = twppc_pkg::TRACE_LEN_DEF,
  parameter int SAMPLE_BITS = twppc_pkg::SAMPLE_BITS_DEF,
  parameter int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_TDATA_W = ((SAMPLE_BITS + 23 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [twppc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [twppc_pkg::REG_W-1:0]     cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_TDATA_W-1:0]           in_tdata,   // sample
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // peak_value, peak_position, peak_found, pulse_count
  output logic [OUT_TDATA_W-1:0]          out_tdata
);
  import twppc_pkg::*;

  cfg_t                   cfg;
  logic                   out_free;
  logic                   step;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last;
  logic                   res_load;
  logic [SAMPLE_BITS-1:0] res_peak_value;
  logic [POS_OUT_W-1:0]   res_peak_position;
  logic                   res_peak_found;
  logic [COUNT_W-1:0]     res_pulse_count;

  twppc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  twppc_in_reg #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .in_tlast  (in_tlast),
    .out_free  (out_free),
    .step      (step),
    .sample    (sample),
    .last      (last)
  );

  twppc_core #(
    .TRACE_LEN   (TRACE_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .step              (step),
    .sample            (sample),
    .last              (last),
    .res_load          (res_load),
    .res_peak_value    (res_peak_value),
    .res_peak_position (res_peak_position),
    .res_peak_found    (res_peak_found),
    .res_pulse_count   (res_pulse_count)
  );

  twppc_out_reg #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TDATA_W     (OUT_TDATA_W)
  ) u_out_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_load          (res_load),
    .res_peak_value    (res_peak_value),
    .res_peak_position (res_peak_position),
    .res_peak_found    (res_peak_found),
    .res_pulse_count   (res_pulse_count),
    .out_free          (out_free),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata)
  );

endmodule
